/* rtl/source_text_tokenizer_macros.svh */
// Assertion macros shared by the tokenizer checker.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define STT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

/* rtl/stt_pkg.sv */
// Shared types and constants for the source text tokenizer.
`default_nettype none

package stt_pkg;

    localparam int KIND_W = 6;
    localparam int FRAC_W = 8;
    localparam int CHAR_W = 8;
    localparam int KW_COUNT = 18;
    localparam int PREFIX_BYTES = 8;
    localparam int Q_DEPTH = 3;

    localparam logic [KIND_W-1:0] KIND_NUMBER = 6'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 6'd1;
    localparam logic [KIND_W-1:0] KIND_KEY0   = 6'd2;
    localparam logic [KIND_W-1:0] KIND_OP0    = 6'd20;
    localparam logic [KIND_W-1:0] KIND_EOL    = 6'd31;
    localparam logic [KIND_W-1:0] KIND_EOF    = 6'd32;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 6'd33;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5f;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_FRAC,
        MODE_WORD,
        MODE_DROP
    } mode_t;

    // Tokens written into the output queue for one accepted byte.
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    // Keywords packed with the first character in the low byte.
    localparam logic [63:0] KW_PACKED [KW_COUNT] = '{
        64'h0000_006c_6163_6f6c,  // local
        64'h0000_6c61_626f_6c67,  // global
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6573_6c65,  // else
        64'h0000_0000_0072_6f66,  // for
        64'h0000_0065_6c69_6877,  // while
        64'h0000_0000_0000_6f64,  // do
        64'h6e6f_6974_636e_7566,  // function
        64'h0000_6e72_7574_6572,  // return
        64'h0000_006b_6165_7262,  // break
        64'h6575_6e69_746e_6f63,  // continue
        64'h0000_0000_6c6f_6f62,  // bool
        64'h0000_0000_0074_6e69,  // int
        64'h0000_0074_616f_6c66,  // float
        64'h0000_676e_6972_7473,  // string
        64'h0000_0065_6c62_6174,  // table
        64'h0000_0000_6575_7274,  // true
        64'h0000_0065_736c_6166   // false
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd2, 4'd8, 4'd6,
        4'd5, 4'd8, 4'd4, 4'd3, 4'd5, 4'd6, 4'd5, 4'd4, 4'd5
    };

    // Map an operator or bracket byte to its offset from KIND_OP0.
    function automatic logic [4:0] op_index(input logic [CHAR_W-1:0] c);
        logic [4:0] idx;
        case (c)
            8'h2b:   idx = 5'd0;   // +
            8'h2d:   idx = 5'd1;   // -
            8'h2a:   idx = 5'd2;   // *
            8'h2f:   idx = 5'd3;   // /
            8'h3d:   idx = 5'd4;   // =
            8'h28:   idx = 5'd5;   // (
            8'h29:   idx = 5'd6;   // )
            8'h7b:   idx = 5'd7;   // {
            8'h7d:   idx = 5'd8;   // }
            8'h5b:   idx = 5'd9;   // [
            8'h5d:   idx = 5'd10;  // ]
            default: idx = 5'd31;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

/* rtl/stt_lexer.sv */
// Byte classifier, token state and token builder of the tokenizer.
`default_nettype none

module stt_lexer
    import stt_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24,
    parameter int MANT_BITS   = 48,
    parameter int KEYWORD_MAX = 8,
    parameter int TOK_W       = KIND_W + 2 * LINE_BITS + 2 * OFFSET_BITS + MANT_BITS
                                + FRAC_W + 1 + CHAR_W + 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [CHAR_W-1:0] ch,
    output logic      [TOK_W-1:0]  tok0,
    output logic      [TOK_W-1:0]  tok1,
    output push_t                  push
);

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   col_reg, col_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   sline_reg, sline_next;
    logic [LINE_BITS-1:0]   scol_reg, scol_next;
    logic [OFFSET_BITS-1:0] soff_reg, soff_next;
    logic [OFFSET_BITS-1:0] len_reg, len_next;
    logic [MANT_BITS-1:0]   mant_reg, mant_next;
    logic [FRAC_W-1:0]      frac_reg, frac_next;
    logic                   ovf_reg, ovf_next;
    logic [63:0]            prefix_reg, prefix_next;

    logic                   is_digit, is_alpha, is_wordc, is_blank, is_op;
    logic [4:0]             op_idx;
    logic                   in_num, cont, starting, restart;
    logic [MANT_BITS+3:0]   mant_x10;
    logic [MANT_BITS-1:0]   mant_add;
    logic                   ovf_add;
    logic [OFFSET_BITS-1:0] len_inc;
    logic [KIND_W-1:0]      word_kind;
    logic                   end_valid, new_valid;
    logic [KIND_W-1:0]      new_kind;
    logic [OFFSET_BITS-1:0] new_len;
    logic [CHAR_W-1:0]      new_bad;
    logic [TOK_W-1:0]       tok_end, tok_new;

    function automatic logic [TOK_W-1:0] pack_tok(
        input logic [KIND_W-1:0]      kind,
        input logic [LINE_BITS-1:0]   ln,
        input logic [LINE_BITS-1:0]   col,
        input logic [OFFSET_BITS-1:0] off,
        input logic [OFFSET_BITS-1:0] len,
        input logic [MANT_BITS-1:0]   mant,
        input logic [FRAC_W-1:0]      frac,
        input logic                   ovf,
        input logic [CHAR_W-1:0]      bad,
        input logic                   fin
    );
        return {kind, ln, col, off, len, mant, frac, ovf, bad, fin};
    endfunction

    always_comb
    begin
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_alpha = ((ch >= 8'h61) && (ch <= 8'h7a)) || ((ch >= 8'h41) && (ch <= 8'h5a));
        is_wordc = is_alpha || is_digit || (ch == CH_UNDER);
        is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR);
        op_idx   = op_index(ch);
        is_op    = (op_idx != 5'd31);

        in_num = (mode_reg == MODE_INT) || (mode_reg == MODE_FRAC);
        cont   = (in_num && is_digit)
               || ((mode_reg == MODE_INT) && (ch == CH_DOT))
               || ((mode_reg == MODE_WORD) && is_wordc)
               || (mode_reg == MODE_DROP);
        starting = !cont;
        restart  = (ch == CH_NUL) && (starting || (mode_reg == MODE_DROP));

        // mantissa * 10 + digit, saturating when the carry leaves the field
        mant_x10 = ({4'b0, mant_reg} << 3) + ({4'b0, mant_reg} << 1)
                 + (MANT_BITS + 4)'(ch[3:0]);
        ovf_add  = ovf_reg || (mant_x10[MANT_BITS+3:MANT_BITS] != 4'd0);
        mant_add = ovf_add ? {MANT_BITS{1'b1}} : mant_x10[MANT_BITS-1:0];
        len_inc  = (len_reg != {OFFSET_BITS{1'b1}}) ? len_reg + 1'b1 : len_reg;

        word_kind = KIND_IDENT;
        if ((len_reg <= OFFSET_BITS'(KEYWORD_MAX)) && (len_reg <= OFFSET_BITS'(PREFIX_BYTES)))
        begin
            for (int i = 0; i < KW_COUNT; i++)
            begin
                if ((len_reg == OFFSET_BITS'(KW_LEN[i])) && (prefix_reg == KW_PACKED[i]))
                    word_kind = KIND_KEY0 + KIND_W'(i);
            end
        end

        // token closed by this byte
        end_valid = starting && (in_num || (mode_reg == MODE_WORD));

        // token opened by this byte, or eof while dropping
        new_valid = 1'b0;
        new_kind  = KIND_ERROR;
        new_len   = OFFSET_BITS'(1);
        new_bad   = '0;
        if (mode_reg == MODE_DROP)
        begin
            new_valid = (ch == CH_NUL);
            new_kind  = KIND_EOF;
            new_len   = '0;
        end
        else if (starting && !is_blank && !is_digit && !is_alpha && (ch != CH_UNDER))
        begin
            new_valid = 1'b1;
            if (is_op)
                new_kind = KIND_OP0 + KIND_W'(op_idx);
            else if (ch == CH_LF)
                new_kind = KIND_EOL;
            else if (ch == CH_NUL)
            begin
                new_kind = KIND_EOF;
                new_len  = '0;
            end
            else
                new_bad = ch;
        end

        tok_end = pack_tok(in_num ? KIND_NUMBER : word_kind, sline_reg, scol_reg, soff_reg,
                           len_reg, in_num ? mant_reg : '0, in_num ? frac_reg : '0,
                           in_num ? ovf_reg : 1'b0, '0, !new_valid);
        tok_new = pack_tok(new_kind, line_reg, col_reg, off_reg, new_len, '0, '0, 1'b0,
                           new_bad, 1'b1);

        tok0        = end_valid ? tok_end : tok_new;
        tok1        = tok_new;
        push.first  = take && (end_valid || new_valid);
        push.second = take && end_valid && new_valid;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        off_next    = off_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        soff_next   = soff_reg;
        len_next    = len_reg;
        mant_next   = mant_reg;
        frac_next   = frac_reg;
        ovf_next    = ovf_reg;
        prefix_next = prefix_reg;

        if (take)
        begin
            // position
            if (restart)
            begin
                line_next = '0;
                col_next  = '0;
                off_next  = '0;
            end
            else
            begin
                if (ch == CH_LF)
                begin
                    col_next = '0;
                    if (line_reg != {LINE_BITS{1'b1}})
                        line_next = line_reg + 1'b1;
                end
                else if (col_reg != {LINE_BITS{1'b1}})
                    col_next = col_reg + 1'b1;
                if (off_reg != {OFFSET_BITS{1'b1}})
                    off_next = off_reg + 1'b1;
            end

            if (cont)
            begin
                case (mode_reg)
                    MODE_INT, MODE_FRAC:
                    begin
                        len_next = len_inc;
                        if (is_digit)
                        begin
                            mant_next = mant_add;
                            ovf_next  = ovf_add;
                            if (mode_reg == MODE_FRAC)
                            begin
                                if (frac_reg != {FRAC_W{1'b1}})
                                    frac_next = frac_reg + 1'b1;
                                else
                                    ovf_next = 1'b1;
                            end
                        end
                        else
                            mode_next = MODE_FRAC;
                    end
                    MODE_WORD:
                    begin
                        len_next = len_inc;
                        if (len_reg < OFFSET_BITS'(PREFIX_BYTES))
                            prefix_next[8 * len_reg[2:0] +: 8] = ch;
                    end
                    MODE_DROP:
                    begin
                        if (ch == CH_NUL)
                            mode_next = MODE_IDLE;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
            else
            begin
                mode_next = MODE_IDLE;
                if (is_digit || is_alpha || (ch == CH_UNDER))
                begin
                    sline_next  = line_reg;
                    scol_next   = col_reg;
                    soff_next   = off_reg;
                    len_next    = OFFSET_BITS'(1);
                    frac_next   = '0;
                    ovf_next    = 1'b0;
                    mant_next   = '0;
                    prefix_next = '0;
                    if (is_digit)
                    begin
                        mode_next = MODE_INT;
                        mant_next = MANT_BITS'(ch[3:0]);
                    end
                    else
                    begin
                        mode_next        = MODE_WORD;
                        prefix_next[7:0] = ch;
                    end
                end
                else if (!is_blank && !is_op && (ch != CH_LF) && (ch != CH_NUL))
                    mode_next = MODE_DROP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            line_reg   <= '0;
            col_reg    <= '0;
            off_reg    <= '0;
            sline_reg  <= '0;
            scol_reg   <= '0;
            soff_reg   <= '0;
            len_reg    <= '0;
            mant_reg   <= '0;
            frac_reg   <= '0;
            ovf_reg    <= 1'b0;
            prefix_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            off_reg    <= off_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
            soff_reg   <= soff_next;
            len_reg    <= len_next;
            mant_reg   <= mant_next;
            frac_reg   <= frac_next;
            ovf_reg    <= ovf_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/stt_queue.sv */
// Three-entry shifting result queue with up to two writes per cycle.
`default_nettype none

module stt_queue
    import stt_pkg::*;
#(
    parameter int WIDTH = 160
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  push_t                 push,
    input  wire logic [WIDTH-1:0] wr0,
    input  wire logic [WIDTH-1:0] wr1,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head,
    output logic                  head_valid,
    output logic                  full
);

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] q_reg   [Q_DEPTH];
    logic [WIDTH-1:0] q_next  [Q_DEPTH];
    logic [WIDTH-1:0] shifted [Q_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] base;
    logic             pop_ok;

    assign head       = q_reg[0];
    assign head_valid = (count_reg != '0);
    // hold off input unless two free slots remain
    assign full       = (count_reg > CNT_W'(Q_DEPTH - 2));
    assign pop_ok     = pop && head_valid;

    always_comb
    begin
        base = count_reg - CNT_W'(pop_ok);
        for (int i = 0; i < Q_DEPTH - 1; i++)
            shifted[i] = pop_ok ? q_reg[i + 1] : q_reg[i];
        shifted[Q_DEPTH-1] = q_reg[Q_DEPTH-1];
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_next[i] = shifted[i];
            if (push.first && (base == CNT_W'(i)))
                q_next[i] = wr0;
            if (push.second && (base + 1'b1 == CNT_W'(i)))
                q_next[i] = wr1;
        end
        count_next = base + CNT_W'(push.first) + CNT_W'(push.second);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

`default_nettype wire

/* rtl/source_text_tokenizer.sv */
// Top level of the streaming source text tokenizer.
// Tokens wait in the result queue, whose head drives the output, behind older ones and
// while tok_stall is high. Throughput: one byte per cycle while ch_stall is low; a byte
// that closes a token and opens another yields two beats, and input then stalls on ch_stall.
// Reset: position, scan mode and accumulators return to zero, the queue empties.
`default_nettype none

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24,
    parameter int MANT_BITS   = 48,
    parameter int KEYWORD_MAX = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // source byte channel
    input  wire logic                   ch_valid,
    output logic                        ch_stall,
    input  wire logic [CHAR_W-1:0]      ch,
    // token channel
    output logic                        tok_valid,
    input  wire logic                   tok_stall,
    output logic      [KIND_W-1:0]      kind,
    output logic      [LINE_BITS-1:0]   tok_line,
    output logic      [LINE_BITS-1:0]   tok_column,
    output logic      [OFFSET_BITS-1:0] tok_offset,
    output logic      [OFFSET_BITS-1:0] tok_length,
    output logic      [MANT_BITS-1:0]   mantissa,
    output logic      [FRAC_W-1:0]      frac_digits,
    output logic                        overflowed,
    output logic      [CHAR_W-1:0]      bad_char,
    output logic                        last
);

    // One token as it sits in the queue, fields in port order.
    localparam int TOK_W = KIND_W + 2 * LINE_BITS + 2 * OFFSET_BITS + MANT_BITS
                         + FRAC_W + 1 + CHAR_W + 1;

    logic             take;
    logic [TOK_W-1:0] tok0, tok1, head;
    push_t            push;

    // A byte beat goes straight into the lexer state; the queue takes the tokens it makes.
    assign take = ch_valid && !ch_stall;

    stt_lexer #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .MANT_BITS   (MANT_BITS),
        .KEYWORD_MAX (KEYWORD_MAX),
        .TOK_W       (TOK_W)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .ch    (ch),
        .tok0  (tok0),
        .tok1  (tok1),
        .push  (push)
    );

    // The queue head is the output register; stall input when it cannot take two more.
    stt_queue #(
        .WIDTH (TOK_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr0        (tok0),
        .wr1        (tok1),
        .pop        (!tok_stall),
        .head       (head),
        .head_valid (tok_valid),
        .full       (ch_stall)
    );

    // Unpack the head token onto the result ports.
    assign {kind, tok_line, tok_column, tok_offset, tok_length, mantissa, frac_digits,
            overflowed, bad_char, last} = head;

endmodule

`default_nettype wire

/* rtl/stt_checker.sv */
// Port-level checks for the tokenizer and their bind.
`default_nettype none

`include "source_text_tokenizer_macros.svh"

module stt_checker
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int MANT_BITS   = 48
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   tok_valid,
    input wire logic                   tok_stall,
    input wire logic [KIND_W-1:0]      kind,
    input wire logic [OFFSET_BITS-1:0] tok_length,
    input wire logic [MANT_BITS-1:0]   mantissa,
    input wire logic [FRAC_W-1:0]      frac_digits,
    input wire logic                   overflowed,
    input wire logic [CHAR_W-1:0]      bad_char
);

    // a stalled token stays put
    `STT_ASSERT_NEXT(a_hold_valid, tok_valid && tok_stall, tok_valid)
    `STT_ASSERT_NEXT(a_hold_kind, tok_valid && tok_stall, $stable(kind) && $stable(tok_length))
    // end of text has no length
    `STT_ASSERT_NOW(a_eof_len, tok_valid && (kind == KIND_EOF), tok_length == '0)
    // only numbers carry a value
    `STT_ASSERT_NOW(a_num_only, tok_valid && (kind != KIND_NUMBER), (mantissa == '0) && (frac_digits == '0) && !overflowed)
    // bad byte set on error tokens alone
    `STT_ASSERT_NOW(a_bad_char, tok_valid, (kind == KIND_ERROR) == (bad_char != '0))

endmodule

bind source_text_tokenizer stt_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .MANT_BITS   (MANT_BITS)
) u_stt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (tok_valid),
    .tok_stall   (tok_stall),
    .kind        (kind),
    .tok_length  (tok_length),
    .mantissa    (mantissa),
    .frac_digits (frac_digits),
    .overflowed  (overflowed),
    .bad_char    (bad_char)
);

`default_nettype wire

/* bench/source_text_tokenizer_tb.sv */
// Self-checking testbench for the streaming source text tokenizer.
module source_text_tokenizer_tb;
    import stt_pkg::*;

    // Sizes of the block under test, kept at its defaults.
    localparam int LINE_BITS   = 16;
    localparam int OFFSET_BITS = 24;
    localparam int MANT_BITS   = 48;
    localparam int KEYWORD_MAX = 8;

    localparam logic [LINE_BITS-1:0]   LINE_TOP   = '1;
    localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = '1;
    localparam logic [MANT_BITS-1:0]   MANT_TOP   = '1;

    // Operator and bracket bytes in token kind order, first byte in the top bits.
    localparam int OP_COUNT = 11;
    localparam logic [8*OP_COUNT-1:0] OP_TEXT = "+-*/=(){}[]";

    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;

    // Lexed bytes to reach in the random part, and the watchdog in time units.
    localparam int RANDOM_TARGET = 1050;
    localparam int RUN_LIMIT     = 12_000_000;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [LINE_BITS-1:0]   ln;
        logic [LINE_BITS-1:0]   col;
        logic [OFFSET_BITS-1:0] off;
        logic [OFFSET_BITS-1:0] len;
        logic [MANT_BITS-1:0]   mant;
        logic [FRAC_W-1:0]      frac;
        logic                   ovf;
        logic [CHAR_W-1:0]      bad;
        logic                   last;
    } token_t;

    // One row of the directed script: the byte and, where it is plain to see,
    // the single token it must give.
    typedef struct {
        logic [CHAR_W-1:0] c;
        bit                typed;
        token_t            want;
    } script_row_t;

    string kw_names [KW_COUNT] = '{
        "local", "global", "if", "else", "for", "while", "do", "function", "return",
        "break", "continue", "bool", "int", "float", "string", "table", "true", "false"
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   ch_valid  = 1'b0;
    logic [CHAR_W-1:0]      ch        = '0;
    logic                   ch_stall;
    logic                   tok_valid;
    logic                   tok_stall = 1'b0;
    logic [KIND_W-1:0]      kind;
    logic [LINE_BITS-1:0]   tok_line;
    logic [LINE_BITS-1:0]   tok_column;
    logic [OFFSET_BITS-1:0] tok_offset;
    logic [OFFSET_BITS-1:0] tok_length;
    logic [MANT_BITS-1:0]   mantissa;
    logic [FRAC_W-1:0]      frac_digits;
    logic                   overflowed;
    logic [CHAR_W-1:0]      bad_char;
    logic                   last;

    // Lexer state mirrored by the predictor.
    mode_t                  scan_state;
    logic [LINE_BITS-1:0]   pos_line, pos_col;
    logic [OFFSET_BITS-1:0] pos_off;
    logic [LINE_BITS-1:0]   open_line, open_col;
    logic [OFFSET_BITS-1:0] open_off, open_len;
    logic [MANT_BITS-1:0]   num_mant;
    logic [FRAC_W-1:0]      num_frac;
    logic                   num_ovf;
    logic [63:0]            word_bytes;

    token_t      step_tokens [$];   // tokens of the byte just lexed
    token_t      tokens_due  [$];   // tokens predicted but not yet seen
    script_row_t script      [$];

    bit idle_en         = 1'b1;
    int stall_left      = 0;
    int fail_count      = 0;
    int items_lexed     = 0;
    int tokens_checked  = 0;
    int two_token_steps = 0;

    source_text_tokenizer #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .MANT_BITS   (MANT_BITS),
        .KEYWORD_MAX (KEYWORD_MAX)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .ch_valid    (ch_valid),
        .ch_stall    (ch_stall),
        .ch          (ch),
        .tok_valid   (tok_valid),
        .tok_stall   (tok_stall),
        .kind        (kind),
        .tok_line    (tok_line),
        .tok_column  (tok_column),
        .tok_offset  (tok_offset),
        .tok_length  (tok_length),
        .mantissa    (mantissa),
        .frac_digits (frac_digits),
        .overflowed  (overflowed),
        .bad_char    (bad_char),
        .last        (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Character classes and token building
    // ------------------------------------------------------------------

    function automatic logic [CHAR_W-1:0] op_char(input int i);
        return OP_TEXT[8*(OP_COUNT-1-i) +: 8];
    endfunction

    function automatic bit is_digit(input logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic bit is_word(input logic [CHAR_W-1:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic token_t make_token(
        input logic [KIND_W-1:0]      k,
        input logic [LINE_BITS-1:0]   ln,
        input logic [LINE_BITS-1:0]   col,
        input logic [OFFSET_BITS-1:0] off,
        input logic [OFFSET_BITS-1:0] len,
        input logic [MANT_BITS-1:0]   mant,
        input logic [FRAC_W-1:0]      frac,
        input logic                   ovf,
        input logic [CHAR_W-1:0]      bad
    );
        token_t t;
        t.kind = k;
        t.ln   = ln;
        t.col  = col;
        t.off  = off;
        t.len  = len;
        t.mant = mant;
        t.frac = frac;
        t.ovf  = ovf;
        t.bad  = bad;
        t.last = 1'b0;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------

    // Move the cursor past one byte; line, column and offset hold at their top.
    function automatic void step_position(input logic [CHAR_W-1:0] c);
        if (c == CH_LF)
        begin
            pos_col = '0;
            if (pos_line != LINE_TOP)
                pos_line++;
        end
        else if (pos_col != LINE_TOP)
        begin
            pos_col++;
        end
        if (c != CH_NUL && pos_off != OFFSET_TOP)
            pos_off++;
    endfunction

    // Accumulate one decimal digit; pin the mantissa at all ones once it would wrap.
    function automatic void take_digit(input logic [CHAR_W-1:0] c);
        logic [MANT_BITS-1:0] d;
        d = MANT_BITS'(c - CH_ZERO);
        if (num_ovf || num_mant > (MANT_TOP - d) / 10)
        begin
            num_mant = MANT_TOP;
            num_ovf  = 1'b1;
        end
        else
        begin
            num_mant = num_mant * 10 + d;
        end
    endfunction

    function automatic void grow_len();
        if (open_len != OFFSET_TOP)
            open_len++;
    endfunction

    function automatic void open_token();
        open_line  = pos_line;
        open_col   = pos_col;
        open_off   = pos_off;
        open_len   = '0;
        num_mant   = '0;
        num_frac   = '0;
        num_ovf    = 1'b0;
        word_bytes = '0;
    endfunction

    function automatic void restart_text();
        pos_line   = '0;
        pos_col    = '0;
        pos_off    = '0;
        scan_state = MODE_IDLE;
    endfunction

    // Identifier or keyword: only words no longer than the keyword limit can match.
    function automatic logic [KIND_W-1:0] word_class();
        logic [63:0] kw_bits;
        if (open_len > KEYWORD_MAX || open_len > 8)
            return KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            kw_bits = '0;
            for (int j = 0; j < kw_names[i].len(); j++)
                kw_bits |= 64'(kw_names[i][j]) << (8 * j);
            if (kw_names[i].len() == open_len && kw_bits == word_bytes)
                return KIND_KEY0 + KIND_W'(i);
        end
        return KIND_IDENT;
    endfunction

    // Lex a byte from the idle state: skip a blank, open a number or word, or give a single token.
    function automatic void start_lexeme(input logic [CHAR_W-1:0] c);
        int opi;
        scan_state = MODE_IDLE;
        opi = -1;
        for (int i = 0; i < OP_COUNT; i++)
            if (c == op_char(i))
                opi = i;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
        begin
            step_position(c);
        end
        else if (is_digit(c))
        begin
            open_token();
            take_digit(c);
            grow_len();
            scan_state = MODE_INT;
            step_position(c);
        end
        else if (is_alpha(c) || c == CH_UNDER)
        begin
            open_token();
            word_bytes = 64'(c);
            grow_len();
            scan_state = MODE_WORD;
            step_position(c);
        end
        else if (opi >= 0)
        begin
            step_tokens.push_back(make_token(KIND_OP0 + KIND_W'(opi), pos_line, pos_col,
                                             pos_off, 1, 0, 0, 1'b0, 0));
            step_position(c);
        end
        else if (c == CH_LF)
        begin
            step_tokens.push_back(make_token(KIND_EOL, pos_line, pos_col, pos_off, 1,
                                             0, 0, 1'b0, 0));
            step_position(c);
        end
        else if (c == CH_NUL)
        begin
            step_tokens.push_back(make_token(KIND_EOF, pos_line, pos_col, pos_off, 0,
                                             0, 0, 1'b0, 0));
            restart_text();
        end
        else
        begin
            // Unknown byte: report it, then drop everything up to the end of text.
            step_tokens.push_back(make_token(KIND_ERROR, pos_line, pos_col, pos_off, 1,
                                             0, 0, 1'b0, c));
            step_position(c);
            scan_state = MODE_DROP;
        end
    endfunction

    // Work out the tokens of one accepted byte into step_tokens.
    function automatic void predict_byte(input logic [CHAR_W-1:0] c);
        step_tokens.delete();
        if (scan_state != MODE_DROP)
            items_lexed++;
        case (scan_state)
            MODE_INT, MODE_FRAC:
            begin
                if (is_digit(c))
                begin
                    take_digit(c);
                    if (scan_state == MODE_FRAC)
                    begin
                        if (num_frac != '1)
                            num_frac++;
                        else
                            num_ovf = 1'b1;
                    end
                    grow_len();
                    step_position(c);
                end
                else if (c == CH_DOT && scan_state == MODE_INT)
                begin
                    scan_state = MODE_FRAC;
                    grow_len();
                    step_position(c);
                end
                else
                begin
                    // The closing byte is lexed in the same beat.
                    step_tokens.push_back(make_token(KIND_NUMBER, open_line, open_col,
                                                     open_off, open_len, num_mant, num_frac,
                                                     num_ovf, 0));
                    start_lexeme(c);
                end
            end
            MODE_WORD:
            begin
                if (is_word(c))
                begin
                    if (open_len < 8)
                        word_bytes |= 64'(c) << (8 * open_len);
                    grow_len();
                    step_position(c);
                end
                else
                begin
                    step_tokens.push_back(make_token(word_class(), open_line, open_col,
                                                     open_off, open_len, 0, 0, 1'b0, 0));
                    start_lexeme(c);
                end
            end
            MODE_DROP:
            begin
                if (c == CH_NUL)
                begin
                    step_tokens.push_back(make_token(KIND_EOF, pos_line, pos_col, pos_off, 0,
                                                     0, 0, 1'b0, 0));
                    restart_text();
                end
                else
                begin
                    step_position(c);
                end
            end
            default:
            begin
                start_lexeme(c);
            end
        endcase
        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
        if (step_tokens.size() == 2)
            two_token_steps++;
    endfunction

    function automatic void queue_predicted();
        foreach (step_tokens[i])
            tokens_due.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------

    // Idle length: mostly none, often a short pause, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] letter();
        if ($urandom_range(0, 1) == 0)
            return CH_LOWER_A + CHAR_W'($urandom_range(0, 25));
        return CH_UPPER_A + CHAR_W'($urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_W-1:0] digit();
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [CHAR_W-1:0] word_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 52)
            return letter();
        if (r < 62)
            return digit();
        return CH_UNDER;
    endfunction

    function automatic logic [CHAR_W-1:0] separator();
        case ($urandom_range(0, 4))
            0, 1:    return CH_SPACE;
            2:       return CH_TAB;
            3:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Source byte side
    // ------------------------------------------------------------------

    // Present one byte, hold it until the beat is taken, then predict its tokens.
    task automatic drive_beat(input logic [CHAR_W-1:0] c);
        int gap;
        gap = idle_en ? pick_idle() : 0;
        repeat (gap)
        begin
            ch_valid <= 1'b0;
            ch       <= CHAR_W'($urandom);
            @(posedge clk);
        end
        ch_valid <= 1'b1;
        ch       <= c;
        @(posedge clk);
        while (ch_stall !== 1'b0)
            @(posedge clk);
        predict_byte(c);
    endtask

    task automatic send_byte(input logic [CHAR_W-1:0] c);
        drive_beat(c);
        queue_predicted();
    endtask

    // Drop valid and hold off until every predicted token has come out.
    task automatic hold_until_drained();
        ch_valid <= 1'b0;
        @(posedge clk);
        while (tokens_due.size() != 0)
            @(posedge clk);
    endtask

    // One random text: mostly well-formed lexemes with random content, some
    // glued together so a byte closes one token and opens the next, with a
    // sprinkling of broken numbers and raw bytes.
    task automatic send_text();
        int    pieces;
        int    pick;
        int    n;
        string kw;
        pieces  = $urandom_range(1, 12);
        idle_en = ($urandom_range(0, 3) != 0);
        for (int p = 0; p < pieces; p++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // Keyword, sometimes stretched into a longer identifier.
                kw = kw_names[$urandom_range(0, KW_COUNT-1)];
                for (int i = 0; i < kw.len(); i++)
                    send_byte(kw[i]);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(word_char());
            end
            else if (pick < 45)
            begin
                send_byte(($urandom_range(0, 7) == 0) ? CH_UNDER : letter());
                repeat ($urandom_range(0, 11)) send_byte(word_char());
            end
            else if (pick < 65)
            begin
                // Number; a tenth are long, and most of those are long enough to pin the mantissa.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
                repeat (n) send_byte(digit());
                if ($urandom_range(0, 2) == 0)
                begin
                    send_byte(CH_DOT);
                    repeat ($urandom_range(0, 5)) send_byte(digit());
                end
            end
            else if (pick < 80)
            begin
                send_byte(op_char($urandom_range(0, OP_COUNT-1)));
            end
            else if (pick < 90)
            begin
                send_byte(separator());
            end
            else if (pick < 95)
            begin
                // Broken number: a second point, or a point with no digits before it.
                if ($urandom_range(0, 1) == 0)
                begin
                    send_byte(digit());
                    send_byte(CH_DOT);
                    if ($urandom_range(0, 1) == 0)
                        send_byte(digit());
                    send_byte(CH_DOT);
                end
                else
                begin
                    send_byte(CH_DOT);
                end
            end
            else
            begin
                send_byte(CHAR_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) < 6)
                send_byte(separator());
        end
        if ($urandom_range(0, 9) != 0)
            send_byte(CH_NUL);
        if ($urandom_range(0, 9) == 0)
            hold_until_drained();
    endtask

    task automatic add_plain(input logic [CHAR_W-1:0] c);
        script.push_back('{c, 1'b0, '0});
    endtask

    task automatic add_typed(input logic [CHAR_W-1:0] c, input token_t want);
        script.push_back('{c, 1'b1, want});
    endtask

    // ------------------------------------------------------------------
    // Token side: random stall, check every beat against the oldest prediction
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_token();
        token_t want;
        if (tokens_due.size() == 0)
        begin
            $error("token beat with nothing expected: kind %0d, offset %0d", kind, tok_offset);
            fail_count++;
            return;
        end
        want = tokens_due.pop_front();
        check_field("kind",        want.kind, kind);
        check_field("tok_line",    want.ln,   tok_line);
        check_field("tok_column",  want.col,  tok_column);
        check_field("tok_offset",  want.off,  tok_offset);
        check_field("tok_length",  want.len,  tok_length);
        check_field("mantissa",    want.mant, mantissa);
        check_field("frac_digits", want.frac, frac_digits);
        check_field("overflowed",  want.ovf,  overflowed);
        check_field("bad_char",    want.bad,  bad_char);
        check_field("last",        want.last, last);
        tokens_checked++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && tok_valid && tok_stall == 1'b0)
            check_token();
        if (stall_left > 0)
            stall_left--;
        else if (idle_en)
            stall_left = pick_idle();
        tok_stall <= (stall_left > 0);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        token_t want;

        restart_text();
        open_token();

        // Directed script. After reset every operator and bracket in turn on
        // line 0, then a newline.
        for (int i = 0; i < OP_COUNT; i++)
            add_typed(op_char(i), make_token(KIND_OP0 + KIND_W'(i), 0, LINE_BITS'(i),
                                             OFFSET_BITS'(i), 1, 0, 0, 1'b0, 0));
        add_typed(CH_LF, make_token(KIND_EOL, 0, 11, 11, 1, 0, 0, 1'b0, 0));
        // "1.5." : the second point closes the number and is itself an error.
        add_plain("1");
        add_plain(CH_DOT);
        add_plain("5");
        add_plain(CH_DOT);
        // Top byte is dropped while skipping; the zero byte ends the text.
        add_plain(8'hff);
        add_typed(CH_NUL, make_token(KIND_EOF, 1, 5, 17, 0, 0, 0, 1'b0, 0));
        // Fresh text: a top byte is an error at the origin.
        add_typed(8'hff, make_token(KIND_ERROR, 0, 0, 0, 1, 0, 0, 1'b0, 8'hff));
        add_typed(CH_NUL, make_token(KIND_EOF, 0, 1, 1, 0, 0, 0, 1'b0, 0));
        // Keyword closed by a carriage return, underscore word closed by end of text.
        add_plain("d");
        add_plain("o");
        add_plain(CH_CR);
        add_plain(CH_UNDER);
        add_plain(CH_NINE);
        add_plain(CH_NUL);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the script with no idling; typed rows give exactly one token.
        idle_en = 1'b0;
        foreach (script[i])
        begin
            drive_beat(script[i].c);
            if (script[i].typed)
            begin
                want      = script[i].want;
                want.last = 1'b1;
                tokens_due.push_back(want);
            end
            else
            begin
                queue_predicted();
            end
        end
        hold_until_drained();

        // Random texts.
        while (items_lexed < RANDOM_TARGET)
            send_text();
        hold_until_drained();

        // Long fraction, run flat out on a fresh text: more fraction digits
        // than the counter holds, which also pins the mantissa.
        idle_en = 1'b0;
        send_byte(CH_NUL);
        send_byte("x");
        send_byte(op_char(4));
        send_byte("1");
        send_byte(CH_DOT);
        repeat (258) send_byte(digit());
        send_byte(CH_LF);
        send_byte("y");
        send_byte(CH_NUL);

        // Drain, then keep clocking so the output queue can show strays.
        ch_valid <= 1'b0;
        @(posedge clk);
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Lexed %0d bytes and checked %0d tokens; %0d bytes gave two tokens.",
                 items_lexed, tokens_checked, two_token_steps);
        $display("Mantissa and fraction count were run past saturation.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #RUN_LIMIT;
        $display("== FAIL ==");
        $finish;
    end

endmodule
